// ----- rtl/core/dfs_pkg.sv -----
// Shared types, widths and codes of the depth-first topological sort block.
package dfs_pkg;

    // Field widths
    localparam int VERTEX_W = 6;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;
    localparam int COLOR_W  = 2;

    // Default capacities
    localparam int MAX_VERTICES_DEF = 64;
    localparam int MAX_EDGES_DEF    = 256;

    typedef logic [VERTEX_W-1:0] vertex_t;
    typedef logic [COUNT_W-1:0]  count_t;
    typedef logic [STATUS_W-1:0] status_t;
    typedef logic [COLOR_W-1:0]  color_t;

    // Vertex marks
    localparam color_t COLOR_WHITE = 2'd0;
    localparam color_t COLOR_GRAY  = 2'd1;
    localparam color_t COLOR_BLACK = 2'd2;

    // Result status codes
    localparam status_t STATUS_OK       = 2'd0;
    localparam status_t STATUS_CYCLE    = 2'd1;
    localparam status_t STATUS_EMPTY    = 2'd2;
    localparam status_t STATUS_OVERFLOW = 2'd3;

endpackage

// ----- rtl/core/dfs_edge_if.sv -----
// Edge input channel: valid/ready handshake with one edge item as payload.
interface dfs_edge_if;
    logic             valid;
    logic             ready;
    dfs_pkg::vertex_t edge_source;
    dfs_pkg::vertex_t edge_target;
    logic             has_edge;
    logic             final_item;

    modport source (output valid, output edge_source, output edge_target,
                    output has_edge, output final_item, input ready);
    modport sink   (input valid, input edge_source, input edge_target,
                    input has_edge, input final_item, output ready);
endinterface

// ----- rtl/core/dfs_order_if.sv -----
// Result output channel: valid/ready handshake with one ordered vertex as payload.
interface dfs_order_if;
    logic             valid;
    logic             ready;
    dfs_pkg::vertex_t order_vertex;
    logic             run_last;
    dfs_pkg::status_t status;

    modport source (output valid, output order_vertex, output run_last,
                    output status, input ready);
    modport sink   (input valid, input order_vertex, input run_last,
                    input status, output ready);
endinterface

// ----- rtl/core/dfs_topological_sort_unit.sv -----
// Depth-first topological sort: edge store, sort sequencer and result register.
//
//  Channel   Direction  Transaction
//  edges     in         one edge (source, target), has_edge, final_item
//  order     out        one vertex of the order, run_last, status
//  cfg       in         vertex count write (cfg_we, cfg_wdata)
//
// Edges load at one transaction per cycle; a final_item starts the sort and edges.ready
// stays low until the run's last result is in the output register. A sort clears the
// colors, checks each root in turn, scans the edge store for each vertex it visits and
// then emits the postorder in reverse.
// Reset clears control state only; stores hold garbage until written.
// A stalled output holds the sequencer in its emit or status state.
module dfs_topological_sort_unit #(
    parameter int MAX_VERTICES = dfs_pkg::MAX_VERTICES_DEF,
    parameter int MAX_EDGES    = dfs_pkg::MAX_EDGES_DEF
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            cfg_we,
    input  dfs_pkg::count_t cfg_wdata,
    dfs_edge_if.sink        edges,
    dfs_order_if.source     order
);
    import dfs_pkg::*;

    localparam int EC_W = $clog2(MAX_EDGES + 1);
    localparam int EA_W = (MAX_EDGES > 1) ? $clog2(MAX_EDGES) : 1;
    localparam int VA_W = (MAX_VERTICES > 1) ? $clog2(MAX_VERTICES) : 1;
    localparam int D_W  = $clog2(MAX_VERTICES + 1);
    localparam count_t          MAX_N    = COUNT_W'(MAX_VERTICES);
    localparam logic [EC_W-1:0] EDGE_CAP = EC_W'(MAX_EDGES);

    // Sequencer states
    localparam logic [3:0] S_LOAD      = 4'd0;
    localparam logic [3:0] S_START     = 4'd1;
    localparam logic [3:0] S_CLEAR     = 4'd2;
    localparam logic [3:0] S_ROOT_RD   = 4'd3;
    localparam logic [3:0] S_ROOT_CHK  = 4'd4;
    localparam logic [3:0] S_EDGE_RD   = 4'd5;
    localparam logic [3:0] S_EDGE_CHK  = 4'd6;
    localparam logic [3:0] S_COLOR_CHK = 4'd7;
    localparam logic [3:0] S_POP       = 4'd8;
    localparam logic [3:0] S_EMIT_RD   = 4'd9;
    localparam logic [3:0] S_EMIT_WAIT = 4'd10;
    localparam logic [3:0] S_SINGLE    = 4'd11;

    // Control registers
    logic [3:0]      state_reg, state_next;
    count_t          vcount_reg;
    count_t          n_reg, n_next;
    logic [EC_W-1:0] loaded_reg, loaded_next;
    logic            overflow_reg, overflow_next;
    count_t          root_reg, root_next;
    vertex_t         top_v_reg, top_v_next;
    logic [EC_W-1:0] top_c_reg, top_c_next;
    logic [D_W-1:0]  depth_reg, depth_next;
    logic [D_W-1:0]  pc_reg, pc_next;
    vertex_t         tgt_reg, tgt_next;
    status_t         single_reg, single_next;

    // Output register
    logic    out_valid_reg, out_valid_next;
    vertex_t out_vertex_reg, out_vertex_next;
    logic    out_last_reg, out_last_next;
    status_t out_status_reg, out_status_next;

    // Memories and their registered read data
    vertex_t         src_mem [MAX_EDGES];
    vertex_t         tgt_mem [MAX_EDGES];
    color_t          color_mem [MAX_VERTICES];
    vertex_t         stk_v_mem [MAX_VERTICES];
    logic [EC_W-1:0] stk_c_mem [MAX_VERTICES];
    vertex_t         post_mem [MAX_VERTICES];
    vertex_t         edge_src_rd_reg;
    vertex_t         edge_tgt_rd_reg;
    color_t          color_rd_reg;
    vertex_t         stk_v_rd_reg;
    logic [EC_W-1:0] stk_c_rd_reg;
    vertex_t         post_rd_reg;

    // Memory port controls
    logic            edge_we, edge_re;
    logic            color_we, color_re;
    logic [VA_W-1:0] color_waddr, color_raddr;
    color_t          color_wdata;
    logic            stk_we, stk_re;
    logic [VA_W-1:0] stk_waddr, stk_raddr;
    logic            post_we, post_re;
    logic [VA_W-1:0] post_raddr;

    logic            in_accept;
    logic            out_free;
    count_t          n_calc;
    logic [D_W-1:0]  depth_m1, depth_m2, pc_m1;

    assign in_accept = edges.valid && edges.ready;
    assign out_free  = !out_valid_reg || order.ready;
    assign n_calc    = (vcount_reg > MAX_N) ? MAX_N : vcount_reg;
    assign depth_m1  = depth_reg - D_W'(1);
    assign depth_m2  = depth_reg - D_W'(2);
    assign pc_m1     = pc_reg - D_W'(1);

    assign edges.ready        = (state_reg == S_LOAD);
    assign order.valid        = out_valid_reg;
    assign order.order_vertex = out_vertex_reg;
    assign order.run_last     = out_last_reg;
    assign order.status       = out_status_reg;

    // Sequencer: load, clear, walk, emit, or report a single status
    always_comb
    begin
        state_next      = state_reg;
        n_next          = n_reg;
        loaded_next     = loaded_reg;
        overflow_next   = overflow_reg;
        root_next       = root_reg;
        top_v_next      = top_v_reg;
        top_c_next      = top_c_reg;
        depth_next      = depth_reg;
        pc_next         = pc_reg;
        tgt_next        = tgt_reg;
        single_next     = single_reg;
        out_valid_next  = out_valid_reg && !order.ready;
        out_vertex_next = out_vertex_reg;
        out_last_next   = out_last_reg;
        out_status_next = out_status_reg;
        edge_we         = 1'b0;
        edge_re         = 1'b0;
        color_we        = 1'b0;
        color_re        = 1'b0;
        color_waddr     = root_reg[VA_W-1:0];
        color_raddr     = root_reg[VA_W-1:0];
        color_wdata     = COLOR_WHITE;
        stk_we          = 1'b0;
        stk_re          = 1'b0;
        stk_waddr       = depth_m1[VA_W-1:0];
        stk_raddr       = depth_m2[VA_W-1:0];
        post_we         = 1'b0;
        post_re         = 1'b0;
        post_raddr      = pc_m1[VA_W-1:0];

        case (state_reg)
            S_LOAD:
            begin
                if (in_accept)
                begin
                    // Store the edge, or flag it as dropped
                    if (edges.has_edge)
                    begin
                        if (loaded_reg < EDGE_CAP)
                        begin
                            edge_we     = 1'b1;
                            loaded_next = loaded_reg + EC_W'(1);
                        end
                        else
                        begin
                            overflow_next = 1'b1;
                        end
                    end
                    if (edges.final_item)
                    begin
                        state_next = S_START;
                    end
                end
            end
            S_START:
            begin
                n_next    = n_calc;
                root_next = '0;
                if (n_calc == '0)
                begin
                    single_next = STATUS_EMPTY;
                    state_next  = S_SINGLE;
                end
                else if (overflow_reg)
                begin
                    single_next = STATUS_OVERFLOW;
                    state_next  = S_SINGLE;
                end
                else
                begin
                    state_next = S_CLEAR;
                end
            end
            S_CLEAR:
            begin
                // Paint one vertex white per cycle
                color_we    = 1'b1;
                color_wdata = COLOR_WHITE;
                root_next   = root_reg + COUNT_W'(1);
                if (root_reg == n_reg - COUNT_W'(1))
                begin
                    root_next  = '0;
                    pc_next    = '0;
                    state_next = S_ROOT_RD;
                end
            end
            S_ROOT_RD:
            begin
                if (root_reg == n_reg)
                begin
                    state_next = S_EMIT_RD;
                end
                else
                begin
                    color_re   = 1'b1;
                    state_next = S_ROOT_CHK;
                end
            end
            S_ROOT_CHK:
            begin
                if (color_rd_reg == COLOR_BLACK)
                begin
                    root_next  = root_reg + COUNT_W'(1);
                    state_next = S_ROOT_RD;
                end
                else
                begin
                    // Start a new tree at this root
                    color_we    = 1'b1;
                    color_wdata = COLOR_GRAY;
                    top_v_next  = VERTEX_W'(root_reg);
                    top_c_next  = '0;
                    depth_next  = D_W'(1);
                    state_next  = S_EDGE_RD;
                end
            end
            S_EDGE_RD:
            begin
                if (top_c_reg < loaded_reg)
                begin
                    edge_re    = 1'b1;
                    top_c_next = top_c_reg + EC_W'(1);
                    state_next = S_EDGE_CHK;
                end
                else
                begin
                    // Out-edges exhausted: retire the vertex
                    color_we    = 1'b1;
                    color_waddr = top_v_reg[VA_W-1:0];
                    color_wdata = COLOR_BLACK;
                    post_we     = 1'b1;
                    pc_next     = pc_reg + D_W'(1);
                    depth_next  = depth_m1;
                    if (depth_reg == D_W'(1))
                    begin
                        root_next  = root_reg + COUNT_W'(1);
                        state_next = S_ROOT_RD;
                    end
                    else
                    begin
                        stk_re     = 1'b1;
                        state_next = S_POP;
                    end
                end
            end
            S_EDGE_CHK:
            begin
                if (edge_src_rd_reg != top_v_reg ||
                    {1'b0, edge_tgt_rd_reg} >= n_reg)
                begin
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    color_re    = 1'b1;
                    color_raddr = edge_tgt_rd_reg[VA_W-1:0];
                    tgt_next    = edge_tgt_rd_reg;
                    state_next  = S_COLOR_CHK;
                end
            end
            S_COLOR_CHK:
            begin
                if (color_rd_reg == COLOR_GRAY)
                begin
                    single_next = STATUS_CYCLE;
                    state_next  = S_SINGLE;
                end
                else if (color_rd_reg == COLOR_BLACK)
                begin
                    state_next = S_EDGE_RD;
                end
                else
                begin
                    // Push: save the current top, descend into the target
                    stk_we      = 1'b1;
                    color_we    = 1'b1;
                    color_waddr = tgt_reg[VA_W-1:0];
                    color_wdata = COLOR_GRAY;
                    top_v_next  = tgt_reg;
                    top_c_next  = '0;
                    depth_next  = depth_reg + D_W'(1);
                    state_next  = S_EDGE_RD;
                end
            end
            S_POP:
            begin
                top_v_next = stk_v_rd_reg;
                top_c_next = stk_c_rd_reg;
                state_next = S_EDGE_RD;
            end
            S_EMIT_RD:
            begin
                post_re    = 1'b1;
                pc_next    = pc_m1;
                state_next = S_EMIT_WAIT;
            end
            S_EMIT_WAIT:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = post_rd_reg;
                    out_last_next   = (pc_reg == '0);
                    out_status_next = STATUS_OK;
                    if (pc_reg == '0)
                    begin
                        loaded_next   = '0;
                        overflow_next = 1'b0;
                        state_next    = S_LOAD;
                    end
                    else
                    begin
                        state_next = S_EMIT_RD;
                    end
                end
            end
            S_SINGLE:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    out_vertex_next = '0;
                    out_last_next   = 1'b1;
                    out_status_next = single_reg;
                    loaded_next     = '0;
                    overflow_next   = 1'b0;
                    state_next      = S_LOAD;
                end
            end
            default:
            begin
                state_next = S_LOAD;
            end
        endcase
    end

    // Control and output registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_LOAD;
            vcount_reg    <= '0;
            loaded_reg    <= '0;
            overflow_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            loaded_reg    <= loaded_next;
            overflow_reg  <= overflow_next;
            out_valid_reg <= out_valid_next;
            if (cfg_we)
            begin
                vcount_reg <= cfg_wdata;
            end
        end
    end

    // Datapath registers, no reset
    always_ff @(posedge clk)
    begin
        n_reg          <= n_next;
        root_reg       <= root_next;
        top_v_reg      <= top_v_next;
        top_c_reg      <= top_c_next;
        depth_reg      <= depth_next;
        pc_reg         <= pc_next;
        tgt_reg        <= tgt_next;
        single_reg     <= single_next;
        out_vertex_reg <= out_vertex_next;
        out_last_reg   <= out_last_next;
        out_status_reg <= out_status_next;
    end

    // Edge store
    always_ff @(posedge clk)
    begin
        if (edge_we)
        begin
            src_mem[loaded_reg[EA_W-1:0]] <= edges.edge_source;
            tgt_mem[loaded_reg[EA_W-1:0]] <= edges.edge_target;
        end
        if (edge_re)
        begin
            edge_src_rd_reg <= src_mem[top_c_reg[EA_W-1:0]];
            edge_tgt_rd_reg <= tgt_mem[top_c_reg[EA_W-1:0]];
        end
    end

    // Color store
    always_ff @(posedge clk)
    begin
        if (color_we)
        begin
            color_mem[color_waddr] <= color_wdata;
        end
        if (color_re)
        begin
            color_rd_reg <= color_mem[color_raddr];
        end
    end

    // Stack below the cached top entry
    always_ff @(posedge clk)
    begin
        if (stk_we)
        begin
            stk_v_mem[stk_waddr] <= top_v_reg;
            stk_c_mem[stk_waddr] <= top_c_reg;
        end
        if (stk_re)
        begin
            stk_v_rd_reg <= stk_v_mem[stk_raddr];
            stk_c_rd_reg <= stk_c_mem[stk_raddr];
        end
    end

    // Postorder buffer
    always_ff @(posedge clk)
    begin
        if (post_we)
        begin
            post_mem[pc_reg[VA_W-1:0]] <= top_v_reg;
        end
        if (post_re)
        begin
            post_rd_reg <= post_mem[post_raddr];
        end
    end

endmodule

// ----- rtl/core/dfs_checker.sv -----
// Port-level checks on the topological sort block, bound to its top level.
module dfs_checker (
    input logic             clk,
    input logic             rst_n,
    input logic             in_valid,
    input logic             in_ready,
    input logic             in_final,
    input logic             out_valid,
    input logic             out_ready,
    input dfs_pkg::vertex_t out_vertex,
    input logic             out_last,
    input dfs_pkg::status_t out_status
);
    import dfs_pkg::*;

    // Hold a stalled result
    property p_out_hold;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(out_vertex) &&
            $stable(out_last) && $stable(out_status);
    endproperty
    assert property (p_out_hold)
        else $error("stalled result changed");

    // Error and empty results close the run and carry vertex zero
    property p_status_single;
        @(posedge clk) disable iff (!rst_n)
        out_valid && out_status != STATUS_OK |-> out_last && out_vertex == '0;
    endproperty
    assert property (p_status_single)
        else $error("non-ok status without run_last or with a vertex");

    // Drop ready once a final item starts the sort
    property p_final_blocks;
        @(posedge clk) disable iff (!rst_n)
        in_valid && in_ready && in_final |=> !in_ready;
    endproperty
    assert property (p_final_blocks)
        else $error("input still ready after final item");

    // A mid-run result means the sort is still busy
    property p_midrun_busy;
        @(posedge clk) disable iff (!rst_n)
        out_valid && !out_last |-> !in_ready;
    endproperty
    assert property (p_midrun_busy)
        else $error("input ready while a run is still emitting");

endmodule

bind dfs_topological_sort_unit dfs_checker u_dfs_checker (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (edges.valid),
    .in_ready   (edges.ready),
    .in_final   (edges.final_item),
    .out_valid  (order.valid),
    .out_ready  (order.ready),
    .out_vertex (order.order_vertex),
    .out_last   (order.run_last),
    .out_status (order.status)
);

// ----- bench/tb_dfs_topological_sort_unit.sv -----
// Testbench for the depth-first topological sort unit: edge stimulus, order prediction, checks.
`timescale 1ns / 1ps

module tb_dfs_topological_sort_unit;

    import dfs_pkg::*;

    localparam int MAX_V = MAX_VERTICES_DEF;
    localparam int MAX_E = MAX_EDGES_DEF;
    // Stall limit, above the longest sort: 64 vertices, each scanning a full edge store
    localparam int STALL_LIMIT = 200000;

    typedef struct packed {
        vertex_t vtx;
        logic    run_last;
        status_t status;
    } order_item_t;

    logic   clk;
    logic   rst_n;
    logic   cfg_we;
    count_t cfg_wdata;

    dfs_edge_if  edge_bus ();
    dfs_order_if order_bus ();

    // Predictor state
    vertex_t     edge_src [MAX_E];
    vertex_t     edge_dst [MAX_E];
    int unsigned stored_edges = 0;
    logic        edge_overflow = 1'b0;
    int unsigned cfg_vertices = 0;
    order_item_t expected_order [$];

    int unsigned error_count = 0;
    int unsigned items_sent = 0;
    int unsigned hold_requests = 0;
    bit          steady_flow = 1'b0;

    dfs_topological_sort_unit #(
        .MAX_VERTICES(MAX_V),
        .MAX_EDGES   (MAX_E)
    ) dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .cfg_we   (cfg_we),
        .cfg_wdata(cfg_wdata),
        .edges    (edge_bus.sink),
        .order    (order_bus.source)
    );

    // Clock
    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Store one accepted item; on the final item work out the expected order
    function automatic void predict_sort(vertex_t src, vertex_t dst, logic carries,
                                         logic closing);
        color_t      mark [MAX_V];
        vertex_t     stack_vtx [MAX_V];
        int unsigned stack_pos [MAX_V];
        vertex_t     finished [MAX_V];
        int unsigned n, root, depth, top, cursor, u, t, done_count, k;
        logic        found_cycle, descended;
        order_item_t item;

        if (carries)
        begin
            if (stored_edges < MAX_E)
            begin
                edge_src[stored_edges] = src;
                edge_dst[stored_edges] = dst;
                stored_edges++;
            end
            else
                edge_overflow = 1'b1;
        end
        if (!closing)
            return;

        n = (cfg_vertices > MAX_V) ? MAX_V : cfg_vertices;
        found_cycle = 1'b0;
        done_count = 0;

        // Walk from every unfinished root, lowest id first
        if (n != 0 && !edge_overflow)
        begin
            for (root = 0; root < MAX_V; root++)
                mark[root] = COLOR_WHITE;
            for (root = 0; root < n && !found_cycle; root++)
            begin
                if (mark[root] != COLOR_BLACK)
                begin
                    mark[root] = COLOR_GRAY;
                    stack_vtx[0] = VERTEX_W'(root);
                    stack_pos[0] = 0;
                    depth = 1;
                    while (depth > 0 && !found_cycle)
                    begin
                        top = depth - 1;
                        u = stack_vtx[top];
                        cursor = stack_pos[top];
                        descended = 1'b0;
                        // Resume the out-edge scan of the top vertex in load order
                        while (cursor < stored_edges && !descended && !found_cycle)
                        begin
                            t = edge_dst[cursor];
                            if (edge_src[cursor] == u && t < n)
                            begin
                                if (mark[t] == COLOR_GRAY)
                                    found_cycle = 1'b1;
                                else if (mark[t] == COLOR_WHITE)
                                begin
                                    stack_pos[top] = cursor + 1;
                                    if (depth < MAX_V)
                                    begin
                                        mark[t] = COLOR_GRAY;
                                        stack_vtx[depth] = VERTEX_W'(t);
                                        stack_pos[depth] = 0;
                                        depth++;
                                    end
                                    descended = 1'b1;
                                end
                            end
                            cursor++;
                        end
                        // Retire the vertex once its edges are exhausted
                        if (!descended && !found_cycle)
                        begin
                            mark[u] = COLOR_BLACK;
                            if (done_count < MAX_V)
                            begin
                                finished[done_count] = VERTEX_W'(u);
                                done_count++;
                            end
                            depth--;
                        end
                    end
                end
            end
        end

        // Empty graph wins over overflow, overflow skips the walk
        if (n == 0 || edge_overflow || found_cycle)
        begin
            item.vtx = '0;
            item.run_last = 1'b1;
            item.status = (n == 0) ? STATUS_EMPTY :
                          edge_overflow ? STATUS_OVERFLOW : STATUS_CYCLE;
            expected_order = {expected_order, item};
        end
        else
        begin
            for (k = 0; k < done_count; k++)
            begin
                item.vtx = finished[done_count - 1 - k];
                item.run_last = (k + 1 == done_count);
                item.status = STATUS_OK;
                expected_order = {expected_order, item};
            end
        end
        stored_edges = 0;
        edge_overflow = 1'b0;
    endfunction

    function automatic void check_field(string field, logic [7:0] want, logic [7:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s expected %0d, actual %0d", $time, field, want, got);
            error_count++;
        end
    endfunction

    // Offer one edge transaction, with random idle cycles ahead of it unless steady_flow is set
    task automatic send_item(input vertex_t src, input vertex_t dst, input logic carries,
                             input logic closing);
        while (!steady_flow && $urandom_range(99) < 35)
        begin
            edge_bus.valid <= 1'b0;
            @(posedge clk);
        end
        edge_bus.valid       <= 1'b1;
        edge_bus.edge_source <= src;
        edge_bus.edge_target <= dst;
        edge_bus.has_edge    <= carries;
        edge_bus.final_item  <= closing;
        @(posedge clk);
        while (!edge_bus.ready)
            @(posedge clk);
        predict_sort(src, dst, carries, closing);
        items_sent++;
    endtask

    // Stop offering and wait until every expected result is out
    task automatic wait_results();
        edge_bus.valid <= 1'b0;
        while (expected_order.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_num_vertices(input count_t value);
        wait_results();
        repeat (4) @(posedge clk);
        cfg_we    <= 1'b1;
        cfg_wdata <= value;
        @(posedge clk);
        cfg_we <= 1'b0;
        cfg_vertices = value;
    endtask

    // One graph: mostly acyclic with random content, some closed loops, some noise
    task automatic send_random_graph();
        int unsigned rank_of [MAX_V];
        int unsigned n, kind, edge_total, i, j, a, b, held;
        logic        closing;

        for (i = 0; i < MAX_V; i++)
            rank_of[i] = i;
        for (i = MAX_V - 1; i > 0; i--)
        begin
            j = $urandom_range(i);
            held = rank_of[i];
            rank_of[i] = rank_of[j];
            rank_of[j] = held;
        end
        n = (cfg_vertices > MAX_V) ? MAX_V : cfg_vertices;
        kind = $urandom_range(99);
        edge_total = $urandom_range(8);
        a = 0;
        b = 0;
        for (i = 0; i <= edge_total; i++)
        begin
            closing = (i == edge_total);
            if (kind >= 85 || n < 2)
                send_item(VERTEX_W'($urandom_range(63)), VERTEX_W'($urandom_range(63)),
                          1'($urandom_range(1)), closing);
            else if (closing && kind >= 70)
                // reverse the last edge to close a loop
                send_item(VERTEX_W'(b), VERTEX_W'(a), 1'b1, 1'b1);
            else
            begin
                a = $urandom_range(n - 1);
                b = $urandom_range(n - 1);
                if (a == b)
                    b = (a + 1) % n;
                if (rank_of[a] > rank_of[b])
                begin
                    held = a;
                    a = b;
                    b = held;
                end
                send_item(VERTEX_W'(a), VERTEX_W'(b),
                          closing ? 1'($urandom_range(1)) : 1'b1, closing);
            end
        end
    endtask

    // Zero vertices, a single vertex, and counts at and above capacity
    task automatic test_degenerate_counts();
        write_num_vertices(0);
        send_item(0, 0, 1'b0, 1'b1);
        send_item(5, 9, 1'b1, 1'b0);
        send_item(9, 5, 1'b1, 1'b1);
        write_num_vertices(1);
        send_item(63, 63, 1'b1, 1'b0);
        send_item(0, 0, 1'b0, 1'b0);
        send_item(0, 0, 1'b0, 1'b1);
        write_num_vertices(127);
        send_item(0, 0, 1'b0, 1'b1);
        write_num_vertices(64);
        send_item(63, 0, 1'b1, 1'b1);
    endtask

    // Small acyclic graph with out-of-range endpoints and an edge on the final item
    task automatic test_small_dag();
        write_num_vertices(5);
        send_item(3, 1, 1'b1, 1'b0);
        send_item(1, 4, 1'b1, 1'b0);
        send_item(0, 3, 1'b1, 1'b0);
        send_item(0, 0, 1'b0, 1'b0);
        send_item(2, 63, 1'b1, 1'b0);
        send_item(40, 2, 1'b1, 1'b0);
        send_item(4, 2, 1'b1, 1'b1);
    endtask

    task automatic test_cycles();
        write_num_vertices(4);
        // self loop
        send_item(2, 2, 1'b1, 1'b0);
        send_item(0, 0, 1'b0, 1'b1);
        // three-vertex loop reached from root 0
        send_item(0, 1, 1'b1, 1'b0);
        send_item(1, 2, 1'b1, 1'b0);
        send_item(2, 0, 1'b1, 1'b1);
        // clean graph right after a loop
        send_item(3, 0, 1'b1, 1'b1);
    endtask

    // Hold the output off so the input stalls behind a sort, then pause the sender
    task automatic test_output_hold();
        write_num_vertices(6);
        hold_requests++;
        send_item(0, 2, 1'b1, 1'b0);
        send_item(2, 5, 1'b1, 1'b0);
        send_item(1, 5, 1'b1, 1'b1);
        send_item(5, 4, 1'b1, 1'b0);
        send_item(4, 3, 1'b1, 1'b1);
        wait_results();
        send_item(3, 0, 1'b1, 1'b1);
    endtask

    task automatic test_random_graphs();
        int unsigned start, graphs, pick;

        start = items_sent;
        graphs = 0;
        steady_flow = 1'b1;
        while (items_sent - start < 85)
        begin
            if (graphs == 8)
                steady_flow = 1'b0;
            if (graphs % 3 == 0)
            begin
                pick = $urandom_range(99);
                if (pick < 6)
                    write_num_vertices(0);
                else if (pick < 12)
                    write_num_vertices(64);
                else if (pick < 18)
                    write_num_vertices(COUNT_W'($urandom_range(127, 65)));
                else if (pick < 28)
                    write_num_vertices(COUNT_W'($urandom_range(63, 17)));
                else
                    write_num_vertices(COUNT_W'($urandom_range(16, 1)));
            end
            send_random_graph();
            graphs++;
        end
        steady_flow = 1'b0;
    endtask

    // Result receiver: random stalls, a long hold-off on request
    initial
    begin
        int unsigned hold_left;
        int unsigned hold_served;
        hold_left = 0;
        hold_served = 0;
        order_bus.ready <= 1'b0;
        forever
        begin
            @(posedge clk);
            if (hold_requests != hold_served)
            begin
                hold_served = hold_requests;
                hold_left = 400;
            end
            if (hold_left > 0)
            begin
                order_bus.ready <= 1'b0;
                hold_left--;
            end
            else if (steady_flow)
                order_bus.ready <= 1'b1;
            else
                order_bus.ready <= ($urandom_range(99) >= 35);
        end
    end

    // Compare each result transaction against the oldest expectation
    always @(posedge clk)
    begin
        order_item_t want;
        if (rst_n && order_bus.valid && order_bus.ready)
        begin
            if (expected_order.size() == 0)
            begin
                $display("%0t ns: unexpected result, vertex %0d, run_last %0d, status %0d",
                         $time, order_bus.order_vertex, order_bus.run_last, order_bus.status);
                error_count++;
            end
            else
            begin
                want = expected_order.pop_front();
                check_field("order_vertex", 8'(want.vtx), 8'(order_bus.order_vertex));
                check_field("run_last", 8'(want.run_last), 8'(order_bus.run_last));
                check_field("status", 8'(want.status), 8'(order_bus.status));
            end
        end
    end

    // Watchdog: end the run when no transaction moves for too long
    initial
    begin
        int unsigned quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < STALL_LIMIT)
        begin
            @(posedge clk);
            if ((edge_bus.valid && edge_bus.ready) || (order_bus.valid && order_bus.ready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("dfs_topological_sort_unit verification failed");
        $finish;
    end

    // Test sequence
    initial
    begin
        rst_n                <= 1'b0;
        cfg_we               <= 1'b0;
        cfg_wdata            <= '0;
        edge_bus.valid       <= 1'b0;
        edge_bus.edge_source <= '0;
        edge_bus.edge_target <= '0;
        edge_bus.has_edge    <= 1'b0;
        edge_bus.final_item  <= 1'b0;
        repeat (8) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        test_degenerate_counts();
        test_small_dag();
        test_cycles();
        test_output_hold();
        test_random_graphs();

        wait_results();
        repeat (50) @(posedge clk);
        if (error_count == 0 && expected_order.size() == 0)
            $display("dfs_topological_sort_unit verification clean");
        else
            $display("dfs_topological_sort_unit verification failed");
        $finish;
    end

endmodule
